// ===== rtl/ebvp_pkg.sv =====
// ----------------------------------------------------------------------------
// ebvp_pkg
// shared widths, symbol codes and helpers of the valence symbol predictor
// ----------------------------------------------------------------------------
package ebvp_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned VERT_W           = 13;
  localparam int unsigned VAL_W            = 16;
  localparam int unsigned SYM_W            = 3;

  // topology symbol codes
  localparam logic [SYM_W-1:0] SYM_C = 3'd0;
  localparam logic [SYM_W-1:0] SYM_S = 3'd1;
  localparam logic [SYM_W-1:0] SYM_L = 3'd3;
  localparam logic [SYM_W-1:0] SYM_R = 3'd5;
  localparam logic [SYM_W-1:0] SYM_E = 3'd7;

  localparam logic [VAL_W-1:0] PREDICT_LIMIT = 16'd6;

  // explicit bit counts reported on decode
  localparam logic [1:0] BITS_NONE  = 2'd0;
  localparam logic [1:0] BITS_SHORT = 2'd1;
  localparam logic [1:0] BITS_LONG  = 2'd3;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_FACE   = 2'd1,
    OP_MERGE  = 2'd2
  } op_e;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/edgebreaker_valence_symbol_predictor_top.sv =====
// ----------------------------------------------------------------------------
// edgebreaker_valence_symbol_predictor_top
// valence table, last symbol and predicted symbol for connectivity decoding
// ----------------------------------------------------------------------------
// Vertex valences live in one synchronous memory of MAX_VERTICES 16-bit words
// with one read and one write port. After reset the block clears every word of
// that memory and holds in_stall_o high meanwhile; register writes are taken
// during the clear. A decode finishes without touching the memory; a merge reads
// the source, reads the destination and writes back, and a face-reached does a
// read-modify-write of corner, next and previous vertex, overlapping each write
// with the read of the following vertex. Items rejected with error also finish
// without touching the memory. A finished result moves into the output register,
// or into a holding register while the output is stalled; while a result waits
// there the block takes no new item.
module edgebreaker_valence_symbol_predictor_top
  import ebvp_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [VERT_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic                     prediction_correct_i,
  input  logic [2:0]               symbol_bits_i,
  input  logic signed [VERT_W-1:0] corner_vertex_i,
  input  logic signed [VERT_W-1:0] next_vertex_i,
  input  logic signed [VERT_W-1:0] previous_vertex_i,
  input  logic signed [VERT_W-1:0] merge_destination_i,
  input  logic signed [VERT_W-1:0] merge_source_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SYM_W-1:0]         symbol_o,
  output logic                     used_prediction_bit_o,
  output logic [1:0]               explicit_bits_used_o,
  output logic                     error_o
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = (AW + 1 > VERT_W) ? AW + 1 : VERT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FACE_C,
    S_FACE_N,
    S_FACE_P,
    S_MERGE_S,
    S_MERGE_D,
    S_HOLD
  } state_e;

  function automatic logic vert_ok(input logic [VERT_W-1:0] f,
                                   input logic [CW-1:0]     lim);
    return !f[VERT_W-1] && (CW'(f[VERT_W-2:0]) < lim);
  endfunction

  function automatic logic [AW-1:0] vert_addr(input logic [VERT_W-1:0] f);
    return AW'(f[VERT_W-2:0]);
  endfunction

  // valence memory
  logic [VAL_W-1:0] mem_q [MAX_VERTICES];
  logic [VAL_W-1:0] rdata_q;
  logic             mem_rd_en, mem_wr_en;
  logic [AW-1:0]    mem_rd_addr, mem_wr_addr;
  logic [VAL_W-1:0] mem_wr_data;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [VERT_W-1:0] count_q, count_d;
  logic [SYM_W-1:0] last_q, last_d;
  logic             last_vld_q, last_vld_d;
  logic [SYM_W-1:0] pred_q, pred_d;
  logic             pred_vld_q, pred_vld_d;
  logic             pred_upd_q, pred_upd_d;
  logic [AW-1:0]    addr_c_q, addr_c_d, addr_n_q, addr_n_d, addr_p_q, addr_p_d;
  logic [1:0]       inc_c_q, inc_c_d, inc_n_q, inc_n_d, inc_p_q, inc_p_d;
  logic [VAL_W-1:0] hold_val_q, hold_val_d;
  logic             fwd_hit_q, fwd_hit_d;
  logic [VAL_W-1:0] fwd_data_q, fwd_data_d;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;
  logic             out_used_q, out_used_d;
  logic [1:0]       out_bits_q, out_bits_d;
  logic             out_err_q, out_err_d;
  logic [SYM_W-1:0] res_sym_q, res_sym_d;
  logic             res_used_q, res_used_d;
  logic [1:0]       res_bits_q, res_bits_d;
  logic             res_err_q, res_err_d;

  logic [CW-1:0]    entries;
  logic             accept, out_free;
  logic [VAL_W-1:0] operand, sum_op, n_final;
  logic             fin;
  state_e           fin_state;
  logic [SYM_W-1:0] r_sym;
  logic             r_used;
  logic [1:0]       r_bits;
  logic             r_err;

  assign entries = (CW'(count_q) < CW'(MAX_VERTICES)) ? CW'(count_q) : CW'(MAX_VERTICES);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // read data bypass when the previous cycle wrote the entry being read
  assign operand    = fwd_hit_q ? fwd_data_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rdata_q <= mem_q[mem_rd_addr];
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    count_d    = cfg_we_i ? cfg_wdata_i : count_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    pred_d     = pred_q;
    pred_vld_d = pred_vld_q;
    pred_upd_d = pred_upd_q;
    addr_c_d   = addr_c_q;
    addr_n_d   = addr_n_q;
    addr_p_d   = addr_p_q;
    inc_c_d    = inc_c_q;
    inc_n_d    = inc_n_q;
    inc_p_d    = inc_p_q;
    hold_val_d = hold_val_q;
    res_sym_d  = res_sym_q;
    res_used_d = res_used_q;
    res_bits_d = res_bits_q;
    res_err_d  = res_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_sym_d  = out_sym_q;
    out_used_d = out_used_q;
    out_bits_d = out_bits_q;
    out_err_d  = out_err_q;

    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    sum_op      = '0;
    n_final     = '0;

    fin       = 1'b0;
    fin_state = S_IDLE;
    r_sym     = SYM_C;
    r_used    = 1'b0;
    r_bits    = BITS_NONE;
    r_err     = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_DECODE: begin
              fin = 1'b1;
              if (pred_vld_q && prediction_correct_i) begin
                r_used = 1'b1;
                r_sym  = pred_q;
              end else begin
                r_used = pred_vld_q;
                if (!symbol_bits_i[0]) begin
                  r_sym  = SYM_C;
                  r_bits = BITS_SHORT;
                end else begin
                  r_sym  = {symbol_bits_i[2:1], 1'b1};
                  r_bits = BITS_LONG;
                end
              end
              last_d     = r_sym;
              last_vld_d = 1'b1;
            end
            OP_FACE: begin
              addr_c_d   = vert_addr(corner_vertex_i);
              addr_n_d   = vert_addr(next_vertex_i);
              addr_p_d   = vert_addr(previous_vertex_i);
              pred_upd_d = (last_q == SYM_C) || (last_q == SYM_R);
              r_err      = !vert_ok(corner_vertex_i, entries) ||
                           !vert_ok(next_vertex_i, entries) ||
                           !vert_ok(previous_vertex_i, entries) || !last_vld_q;
              case (last_q)
                SYM_C, SYM_S: begin
                  inc_c_d = 2'd0; inc_n_d = 2'd1; inc_p_d = 2'd1;
                end
                SYM_R: begin
                  inc_c_d = 2'd1; inc_n_d = 2'd1; inc_p_d = 2'd2;
                end
                SYM_L: begin
                  inc_c_d = 2'd1; inc_n_d = 2'd2; inc_p_d = 2'd1;
                end
                SYM_E: begin
                  inc_c_d = 2'd2; inc_n_d = 2'd2; inc_p_d = 2'd2;
                end
                default: begin
                  r_err = 1'b1;
                end
              endcase
              if (r_err) begin
                fin = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = vert_addr(corner_vertex_i);
                state_d     = S_FACE_C;
              end
            end
            OP_MERGE: begin
              addr_n_d = vert_addr(merge_destination_i);
              if (!vert_ok(merge_destination_i, entries) ||
                  !vert_ok(merge_source_i, entries)) begin
                fin   = 1'b1;
                r_err = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = vert_addr(merge_source_i);
                state_d     = S_MERGE_S;
              end
            end
            default: begin
              fin   = 1'b1;
              r_err = 1'b1;
            end
          endcase
        end
      end
      S_FACE_C: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_c_q;
        mem_wr_data = sat_add(operand, VAL_W'(inc_c_q));
        mem_rd_en   = 1'b1;
        mem_rd_addr = addr_n_q;
        state_d     = S_FACE_N;
      end
      S_FACE_N: begin
        sum_op      = sat_add(operand, VAL_W'(inc_n_q));
        hold_val_d  = sum_op;
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_n_q;
        mem_wr_data = sum_op;
        mem_rd_en   = 1'b1;
        mem_rd_addr = addr_p_q;
        state_d     = S_FACE_P;
      end
      S_FACE_P: begin
        sum_op      = sat_add(operand, VAL_W'(inc_p_q));
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_p_q;
        mem_wr_data = sum_op;
        // next vertex valence after all three increments
        n_final     = (addr_p_q == addr_n_q) ? sum_op : hold_val_q;
        pred_vld_d  = pred_upd_q;
        if (pred_upd_q) begin
          pred_d = (n_final < PREDICT_LIMIT) ? SYM_R : SYM_C;
        end
        fin = 1'b1;
      end
      S_MERGE_S: begin
        hold_val_d  = operand;
        mem_rd_en   = 1'b1;
        mem_rd_addr = addr_n_q;
        state_d     = S_MERGE_D;
      end
      S_MERGE_D: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_n_q;
        mem_wr_data = sat_add(operand, hold_val_q);
        fin         = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = res_sym_q;
          out_used_d  = res_used_q;
          out_bits_d  = res_bits_q;
          out_err_d   = res_err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a finished item goes to the output, or waits in the holding register
    if (fin) begin
      if (r_err) begin
        r_sym  = SYM_C;
        r_used = 1'b0;
        r_bits = BITS_NONE;
      end
      if (out_free) begin
        out_valid_d = 1'b1;
        out_sym_d   = r_sym;
        out_used_d  = r_used;
        out_bits_d  = r_bits;
        out_err_d   = r_err;
        state_d     = fin_state;
      end else begin
        res_sym_d  = r_sym;
        res_used_d = r_used;
        res_bits_d = r_bits;
        res_err_d  = r_err;
        state_d    = S_HOLD;
      end
    end

    fwd_hit_d  = mem_rd_en ? (mem_wr_en && (mem_wr_addr == mem_rd_addr)) : fwd_hit_q;
    fwd_data_d = mem_rd_en ? mem_wr_data : fwd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      last_vld_q  <= 1'b0;
      pred_vld_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      last_vld_q  <= last_vld_d;
      pred_vld_q  <= pred_vld_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    pred_q     <= pred_d;
    pred_upd_q <= pred_upd_d;
    addr_c_q   <= addr_c_d;
    addr_n_q   <= addr_n_d;
    addr_p_q   <= addr_p_d;
    inc_c_q    <= inc_c_d;
    inc_n_q    <= inc_n_d;
    inc_p_q    <= inc_p_d;
    hold_val_q <= hold_val_d;
    fwd_data_q <= fwd_data_d;
    out_sym_q  <= out_sym_d;
    out_used_q <= out_used_d;
    out_bits_q <= out_bits_d;
    out_err_q  <= out_err_d;
    res_sym_q  <= res_sym_d;
    res_used_q <= res_used_d;
    res_bits_q <= res_bits_d;
    res_err_q  <= res_err_d;
  end

  assign out_valid_o           = out_valid_q;
  assign symbol_o              = out_sym_q;
  assign used_prediction_bit_o = out_used_q;
  assign explicit_bits_used_o  = out_bits_q;
  assign error_o               = out_err_q;

endmodule

// ===== rtl/ebvp_checker.sv =====
// ----------------------------------------------------------------------------
// ebvp_checker
// port-level checks of the valence symbol predictor, bound to the top level
// ----------------------------------------------------------------------------
module ebvp_checker
  import ebvp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SYM_W-1:0] symbol_o,
  input logic             used_prediction_bit_o,
  input logic [1:0]       explicit_bits_used_o,
  input logic             error_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(symbol_o) && $stable(error_o) &&
      $stable(explicit_bits_used_o) && $stable(used_prediction_bit_o))
    else $error("stalled result changed");

  // errored transfers carry no decode information
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |->
      symbol_o == SYM_C && !used_prediction_bit_o && explicit_bits_used_o == BITS_NONE)
    else $error("error result with decode fields set");

  // explicit bit count matches the symbol code
  a_bits_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (explicit_bits_used_o == BITS_NONE) ||
      (explicit_bits_used_o == BITS_SHORT && symbol_o == SYM_C) ||
      (explicit_bits_used_o == BITS_LONG && symbol_o[0]))
    else $error("explicit bit count inconsistent with symbol");

  // a symbol taken from the prediction alone is C or R
  a_pred_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && used_prediction_bit_o && explicit_bits_used_o == BITS_NONE |->
      symbol_o == SYM_C || symbol_o == SYM_R)
    else $error("predicted symbol neither C nor R");

endmodule

bind edgebreaker_valence_symbol_predictor_top ebvp_checker u_ebvp_checker (.*);
